>>> design/msc_pkg.sv
// msc_pkg: shared widths, register codes and the attenuation scale helper
// for the microphone sample conditioner. No dependencies.

package msc_pkg;

	// field and state widths
	localparam int WORD_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 16;
	localparam int CH_LEVEL_W = 18;
	localparam int ACC_W      = 27;

	// default shifts for the top-level parameters
	localparam int INPUT_SHIFT_DEF = 14;
	localparam int DC_SHIFT_DEF    = 8;

	// configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIC_MODE = 2'd0,
		CFG_INT_MODE = 2'd1,
		CFG_ATTEN    = 2'd2
	} cfg_index_t;

	// channel selection; the unused code falls back to the average
	typedef enum logic [1:0] {
		MODE_AVG   = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2
	} mic_mode_t;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// attenuation: out = x * (100 - att) / 100, done as x * scale >> RECIP_SHIFT
	localparam int ATTEN_RESET = 75;
	localparam int ATTEN_MAX   = 100;
	localparam int PERCENT     = 100;
	localparam int RECIP_SHIFT = 29;
	localparam int SCALE_W     = 30;
	localparam logic [SCALE_W-1:0] RECIP_100 =
		SCALE_W'(((64'd1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT);

	// conditioned sample between the dc stage and the scaling stage
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CH_LEVEL_W-1:0]      lvl_left;
		logic [CH_LEVEL_W-1:0]      lvl_right;
		logic                       clr;
	} cond_t;

	// scale factor for an attenuation setting; out-of-range settings act as the default
	function automatic logic [SCALE_W-1:0] atten_scale(input logic [CFG_W-1:0] att);
		logic [CFG_W-1:0] eff;
		logic [CFG_W-1:0] keep;
		eff  = (att > CFG_W'(ATTEN_MAX)) ? CFG_W'(ATTEN_RESET) : att;
		keep = CFG_W'(PERCENT) - eff;
		return {{(SCALE_W-CFG_W){1'b0}}, keep} * RECIP_100;
	endfunction

endpackage

>>> design/mic_sample_conditioner.sv
// mic_sample_conditioner: channel select, dc blocking, saturation, attenuation
// and peak metering of microphone samples. Depends on msc_pkg.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  kind, left_word, right_word,
//                                            processed_sample, clear_levels
//   out      source     out_valid/out_stall  sample_out, level_out,
//                                            level_left, level_right
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// one transaction per cycle sustained while the output is not stalled; three register stages (input register,
// dc/saturate stage, attenuation multiply stage into the output register).
// the dc accumulator and the peaks each close their loop through their own register alone.
// a stalled output freezes all three stages; in_stall is high only then.
// arst_n clears valid bits, accumulator, peaks and config to reset values.

module mic_sample_conditioner #(
	parameter int INPUT_SHIFT = msc_pkg::INPUT_SHIFT_DEF,
	parameter int DC_SHIFT    = msc_pkg::DC_SHIFT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [msc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [msc_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic signed [msc_pkg::WORD_W-1:0]      left_word,
	input  logic signed [msc_pkg::WORD_W-1:0]      right_word,
	input  logic signed [msc_pkg::SAMPLE_W-1:0]    processed_sample,
	input  logic                                   clear_levels,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [msc_pkg::SAMPLE_W-1:0]    sample_out,
	output logic [msc_pkg::LEVEL_W-1:0]            level_out,
	output logic [msc_pkg::CH_LEVEL_W-1:0]         level_left,
	output logic [msc_pkg::CH_LEVEL_W-1:0]         level_right
);
	import msc_pkg::*;

	localparam int CH_W  = WORD_W - INPUT_SHIFT;
	localparam int SUM_W = CH_W + 1;
	localparam int MAG_W = (CH_W > CH_LEVEL_W) ? CH_W : CH_LEVEL_W;
	localparam int Y_W   = ACC_W + 1;
	localparam int PROD_W = SAMPLE_W + SCALE_W;
	localparam logic [CH_LEVEL_W-1:0] CH_LEVEL_MAX = '1;

	// configuration registers
	mic_mode_t          mic_mode_q;
	logic               int_mode_q;
	logic [SCALE_W-1:0] scale_q;

	// pipeline control
	logic advance;
	logic v_s1, v_s2, out_valid_q;

	// stage 1 payload
	logic                       kind_s1, clr_s1;
	logic signed [WORD_W-1:0]   left_s1, right_s1;
	logic signed [SAMPLE_W-1:0] proc_s1;

	// state
	logic signed [ACC_W-1:0] acc_q;
	logic [CH_LEVEL_W-1:0]   peak_left_q, peak_right_q;
	logic [LEVEL_W-1:0]      peak_output_q;

	// stage 2 / output payload
	cond_t                      s2_q;
	logic signed [SAMPLE_W-1:0] sample_s3;
	logic [LEVEL_W-1:0]         level_s3;
	logic [CH_LEVEL_W-1:0]      lvl_left_s3, lvl_right_s3;

	// the whole pipe moves unless a finished result is held back
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mic_mode_q <= MODE_AVG;
			int_mode_q <= 1'b0;
			scale_q    <= atten_scale(CFG_W'(ATTEN_RESET));
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIC_MODE: mic_mode_q <= mic_mode_t'(cfg_data[1:0]);
				CFG_INT_MODE: int_mode_q <= cfg_data[0];
				CFG_ATTEN:    scale_q    <= atten_scale(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			kind_s1  <= kind;
			clr_s1   <= clear_levels;
			left_s1  <= left_word;
			right_s1 <= right_word;
			proc_s1  <= processed_sample;
		end
	end

	// channel extraction: arithmetic shift is the upper slice of the word
	logic signed [CH_W-1:0] ch_l, ch_r;
	logic [CH_W-1:0]        abs_l, abs_r;
	logic [MAG_W-1:0]       mag_l, mag_r;
	logic [CH_LEVEL_W-1:0]  sat_l, sat_r, pk_l_new, pk_r_new;

	assign ch_l  = $signed(left_s1[WORD_W-1:INPUT_SHIFT]);
	assign ch_r  = $signed(right_s1[WORD_W-1:INPUT_SHIFT]);
	assign abs_l = ch_l[CH_W-1] ? CH_W'(-ch_l) : CH_W'(ch_l);
	assign abs_r = ch_r[CH_W-1] ? CH_W'(-ch_r) : CH_W'(ch_r);
	assign mag_l = MAG_W'(abs_l);
	assign mag_r = MAG_W'(abs_r);

	// channel peaks saturate at the level field's full scale
	assign sat_l = (mag_l > MAG_W'(CH_LEVEL_MAX)) ? CH_LEVEL_MAX : CH_LEVEL_W'(mag_l);
	assign sat_r = (mag_r > MAG_W'(CH_LEVEL_MAX)) ? CH_LEVEL_MAX : CH_LEVEL_W'(mag_r);
	assign pk_l_new = (sat_l > peak_left_q)  ? sat_l : peak_left_q;
	assign pk_r_new = (sat_r > peak_right_q) ? sat_r : peak_right_q;

	// mono selection
	logic signed [SUM_W-1:0] ch_sum;
	logic signed [CH_W-1:0]  mono;

	assign ch_sum = {ch_l[CH_W-1], ch_l} + {ch_r[CH_W-1], ch_r};

	always_comb begin
		case (mic_mode_q)
			MODE_LEFT:  mono = ch_l;
			MODE_RIGHT: mono = ch_r;
			default:    mono = $signed(ch_sum[SUM_W-1:1]);
		endcase
	end

	// dc blocking integrator, wrapping at the accumulator width
	logic signed [ACC_W-1:0] mono_acc, acc_next;
	logic signed [Y_W-1:0]   mono_wide, acc_wide, dc_out;
	logic [Y_W-SAMPLE_W:0]   dc_hi;
	logic signed [SAMPLE_W-1:0] dc_sat;

	assign mono_acc  = {{(ACC_W-CH_W){mono[CH_W-1]}}, mono};
	assign acc_next  = acc_q + mono_acc - (acc_q >>> DC_SHIFT);
	assign mono_wide = {{(Y_W-CH_W){mono[CH_W-1]}}, mono};
	assign acc_wide  = {acc_next[ACC_W-1], acc_next};
	assign dc_out    = mono_wide - (acc_wide >>> DC_SHIFT);

	// saturate to the sample width
	assign dc_hi = dc_out[Y_W-1:SAMPLE_W-1];

	always_comb begin
		if (dc_hi == '0 || dc_hi == '1) begin
			dc_sat = dc_out[SAMPLE_W-1:0];
		end else if (dc_out[Y_W-1]) begin
			dc_sat = SAMPLE_MIN;
		end else begin
			dc_sat = SAMPLE_MAX;
		end
	end

	cond_t cond;

	always_comb begin
		cond.clr = clr_s1;
		if (kind_s1) begin
			cond.sample    = proc_s1;
			cond.lvl_left  = peak_left_q;
			cond.lvl_right = peak_right_q;
		end else begin
			cond.sample    = dc_sat;
			cond.lvl_left  = pk_l_new;
			cond.lvl_right = pk_r_new;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			s2_q <= cond;
		end
	end

	// stage 3: attenuation by reciprocal multiply on the magnitude when int_mode is set, else pass-through
	logic                    s2_neg;
	logic [SAMPLE_W-1:0]     s2_mag, att_mag, res_mag, pk_out_new;
	logic [PROD_W-1:0]       prod;
	logic signed [SAMPLE_W-1:0] att_sample, res_sample;

	assign s2_neg     = s2_q.sample[SAMPLE_W-1];
	assign s2_mag     = s2_neg ? SAMPLE_W'(-s2_q.sample) : SAMPLE_W'(s2_q.sample);
	assign prod       = {{SCALE_W{1'b0}}, s2_mag} * {{SAMPLE_W{1'b0}}, scale_q};
	assign att_mag    = prod[RECIP_SHIFT +: SAMPLE_W];
	assign att_sample = s2_neg ? $signed(SAMPLE_W'(-att_mag)) : $signed(att_mag);
	assign res_sample = int_mode_q ? att_sample : s2_q.sample;
	assign res_mag    = int_mode_q ? att_mag : s2_mag;
	assign pk_out_new = (res_mag > peak_output_q) ? res_mag : peak_output_q;

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && v_s2) begin
			sample_s3    <= res_sample;
			level_s3     <= pk_out_new;
			lvl_left_s3  <= s2_q.lvl_left;
			lvl_right_s3 <= s2_q.lvl_right;
		end
	end

	// valid bits, accumulator and peaks; clears land after the result is formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
			acc_q         <= '0;
			peak_left_q   <= '0;
			peak_right_q  <= '0;
			peak_output_q <= '0;
		end else if (advance) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (v_s1) begin
				if (!kind_s1) begin
					acc_q <= acc_next;
				end
				peak_left_q  <= clr_s1 ? '0 : cond.lvl_left;
				peak_right_q <= clr_s1 ? '0 : cond.lvl_right;
			end
			if (v_s2) begin
				peak_output_q <= s2_q.clr ? '0 : pk_out_new;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_s3;
	assign level_out   = level_s3;
	assign level_left  = lvl_left_s3;
	assign level_right = lvl_right_s3;

`ifndef SYNTHESIS
	// input is held back only by a stalled, valid result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// the reported output peak covers the sample it travels with
	a_level_cover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_out >= (sample_out[SAMPLE_W-1] ?
			(SAMPLE_W'(0) - $unsigned(sample_out)) : $unsigned(sample_out))))
		else $error("output level below sample magnitude");

	// a clear request empties the channel peaks once its item moves on
	a_clear_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s1 && clr_s1) |=> (peak_left_q == '0 && peak_right_q == '0))
		else $error("channel peaks not cleared");
`endif

endmodule
